// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the rewriter.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/p2sr_pkg.sv =====
// Package for the power-of-two strength reduction rewriter.
// Opcode and operand kind codes, beat layouts, power-of-two test.
package p2sr_pkg;

  localparam int NumVregsDefault = 256;

  localparam logic [5:0] OP_MUL     = 6'd0;
  localparam logic [5:0] OP_DIV     = 6'd1;
  localparam logic [5:0] OP_MOD     = 6'd2;
  localparam logic [5:0] OP_MOVI    = 6'd3;
  localparam logic [5:0] OP_MOV     = 6'd4;
  localparam logic [5:0] OP_SHL     = 6'd5;
  localparam logic [5:0] OP_SDIV_P2 = 6'd6;
  localparam logic [5:0] OP_UDIV_P2 = 6'd7;
  localparam logic [5:0] OP_SMOD_P2 = 6'd8;
  localparam logic [5:0] OP_UMOD_P2 = 6'd9;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_IMM  = 2'd1;
  localparam logic [1:0] KIND_REG  = 2'd2;

  localparam int InDataW  = 160;
  localparam int InUserW  = 7;
  localparam int OutDataW = 160;
  localparam int OutUserW = 5;

  typedef struct packed {
    logic        block_start;
    logic [5:0]  opcode;
    logic        is_unsigned;
    logic        dst_valid;
    logic [7:0]  dst_reg;
    logic [1:0]  a_kind;
    logic [63:0] a_imm;
    logic [7:0]  a_reg;
    logic [1:0]  b_kind;
    logic [63:0] b_imm;
    logic [7:0]  b_reg;
  } item_t;

  typedef struct packed {
    logic [5:0]  new_opcode;
    logic [1:0]  out_a_kind;
    logic [63:0] out_a_imm;
    logic [7:0]  out_a_reg;
    logic [1:0]  out_b_kind;
    logic [63:0] out_b_imm;
    logic [7:0]  out_b_reg;
    logic [5:0]  shift_amount;
    logic        was_changed;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] k;
  } pow2_t;

  // positive power of two test with log2 encode
  function automatic pow2_t pow2_log(input logic [63:0] v);
    pow2_t r;
    r.ok = (v != 64'd0) && !v[63] && ((v & (v - 64'd1)) == 64'd0);
    r.k  = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        r.k = r.k | 6'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/p2sr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module p2sr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pow2_strength_reduce_rewriter.sv =====
// Power-of-two strength reduction rewriter, top level.
// Uses p2sr_pkg, p2sr_ram and assert_macros.svh.
//
// One instruction per beat on s_*, one rewritten instruction per beat on m_*.
// A beat is taken when tvalid and tready are both high. An accepted beat is
// captured in stage 1, and its result is then registered in the output register
// that drives m_*. Throughput is one beat per cycle while the output is not held:
// stage 1 holds the item while the two constant-value RAMs (one per operand port)
// deliver their registered read, and the output register holds the result. Stage 1
// takes a beat when it is empty or when the output register moves or is empty.
// Known marks sit in flip-flops; a set block_start clears them all before the
// beat's own lookups. Constant values live in RAM and are only used when the
// mark is set; the last write is forwarded over the RAM read.
// When m_tready is low the result holds, stage 1 fills, and then s_tready
// drops. Reset empties both stages and clears every mark; no clearing pass.
module pow2_strength_reduce_rewriter #(
  parameter int NUM_VREGS = p2sr_pkg::NumVregsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode, dst_reg, a_imm, a_reg, b_imm, b_reg, zero pad
  input  logic [p2sr_pkg::InDataW-1:0]  s_tdata,
  // block_start, is_unsigned, dst_valid, a_kind, b_kind
  input  logic [p2sr_pkg::InUserW-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // new_opcode, out_a_imm, out_a_reg, out_b_imm, out_b_reg, shift_amount, zero pad
  output logic [p2sr_pkg::OutDataW-1:0] m_tdata,
  // out_a_kind, out_b_kind, was_changed
  output logic [p2sr_pkg::OutUserW-1:0] m_tuser
);

  localparam int IDX_W = $clog2(NUM_VREGS);

  p2sr_pkg::item_t   in_item;
  p2sr_pkg::item_t   s1;
  logic              s1_valid;
  logic              s1_go;
  logic              accept;
  logic              out_ready;
  p2sr_pkg::result_t res;
  p2sr_pkg::result_t res_next;
  logic              out_valid;

  logic [NUM_VREGS-1:0] mark;
  logic [NUM_VREGS-1:0] mark_next;

  logic [IDX_W-1:0] raddr_a, raddr_b;
  logic [63:0]      rdata_a, rdata_b;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [63:0]      wr_val;
  logic             lw_en;
  logic [IDX_W-1:0] lw_addr;
  logic [63:0]      lw_data;

  always_comb begin
    in_item.block_start = s_tuser[0];
    in_item.is_unsigned = s_tuser[1];
    in_item.dst_valid   = s_tuser[2];
    in_item.a_kind      = s_tuser[4:3];
    in_item.b_kind      = s_tuser[6:5];
    in_item.opcode      = s_tdata[5:0];
    in_item.dst_reg     = s_tdata[13:6];
    in_item.a_imm       = s_tdata[77:14];
    in_item.a_reg       = s_tdata[85:78];
    in_item.b_imm       = s_tdata[149:86];
    in_item.b_reg       = s_tdata[157:150];
  end

  assign out_ready = !out_valid || m_tready;
  assign s1_go     = s1_valid && out_ready;
  assign s_tready  = !s1_valid || s1_go;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (accept) begin
      s1 <= in_item;
    end
  end

  // re-read the held item's addresses while stage 1 waits
  assign raddr_a = accept ? IDX_W'(in_item.a_reg) : IDX_W'(s1.a_reg);
  assign raddr_b = accept ? IDX_W'(in_item.b_reg) : IDX_W'(s1.b_reg);

  p2sr_ram #(.WIDTH(64), .DEPTH(NUM_VREGS)) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_val),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  p2sr_ram #(.WIDTH(64), .DEPTH(NUM_VREGS)) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_val),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // stage 1 rewrite
  logic [IDX_W-1:0]    a_idx, b_idx;
  logic                a_in, b_in, d_in;
  logic                a_known, b_known;
  logic [63:0]         a_val, b_val;
  p2sr_pkg::pow2_t     pa, pb;
  logic                wr_mark;

  always_comb begin
    a_idx   = IDX_W'(s1.a_reg);
    b_idx   = IDX_W'(s1.b_reg);
    wr_idx  = IDX_W'(s1.dst_reg);
    a_in    = 32'(s1.a_reg) < NUM_VREGS;
    b_in    = 32'(s1.b_reg) < NUM_VREGS;
    d_in    = 32'(s1.dst_reg) < NUM_VREGS;
    a_known = (s1.a_kind == p2sr_pkg::KIND_IMM) ||
              (s1.a_kind == p2sr_pkg::KIND_REG && a_in && !s1.block_start && mark[a_idx]);
    b_known = (s1.b_kind == p2sr_pkg::KIND_IMM) ||
              (s1.b_kind == p2sr_pkg::KIND_REG && b_in && !s1.block_start && mark[b_idx]);
    if (s1.a_kind == p2sr_pkg::KIND_IMM) begin
      a_val = s1.a_imm;
    end else if (lw_en && lw_addr == a_idx) begin
      a_val = lw_data;
    end else begin
      a_val = rdata_a;
    end
    if (s1.b_kind == p2sr_pkg::KIND_IMM) begin
      b_val = s1.b_imm;
    end else if (lw_en && lw_addr == b_idx) begin
      b_val = lw_data;
    end else begin
      b_val = rdata_b;
    end
    pa = p2sr_pkg::pow2_log(a_val);
    pb = p2sr_pkg::pow2_log(b_val);

    res_next.new_opcode   = s1.opcode;
    res_next.out_a_kind   = s1.a_kind;
    res_next.out_a_imm    = s1.a_imm;
    res_next.out_a_reg    = s1.a_reg;
    res_next.out_b_kind   = s1.b_kind;
    res_next.out_b_imm    = s1.b_imm;
    res_next.out_b_reg    = s1.b_reg;
    res_next.shift_amount = 6'd0;
    res_next.was_changed  = 1'b0;

    case (s1.opcode)
      p2sr_pkg::OP_MUL: begin
        if (b_known && pb.ok) begin
          res_next.new_opcode  = p2sr_pkg::OP_SHL;
          res_next.out_b_kind  = p2sr_pkg::KIND_IMM;
          res_next.out_b_imm   = 64'(pb.k);
          res_next.out_b_reg   = 8'd0;
          res_next.was_changed = 1'b1;
        end else if (a_known && pa.ok) begin
          res_next.new_opcode  = p2sr_pkg::OP_SHL;
          res_next.out_a_kind  = s1.b_kind;
          res_next.out_a_imm   = s1.b_imm;
          res_next.out_a_reg   = s1.b_reg;
          res_next.out_b_kind  = p2sr_pkg::KIND_IMM;
          res_next.out_b_imm   = 64'(pa.k);
          res_next.out_b_reg   = 8'd0;
          res_next.was_changed = 1'b1;
        end
      end
      p2sr_pkg::OP_DIV, p2sr_pkg::OP_MOD: begin
        if (b_known && pb.ok) begin
          if (s1.is_unsigned) begin
            res_next.new_opcode = (s1.opcode == p2sr_pkg::OP_DIV) ?
                                  p2sr_pkg::OP_UDIV_P2 : p2sr_pkg::OP_UMOD_P2;
          end else begin
            res_next.new_opcode = (s1.opcode == p2sr_pkg::OP_DIV) ?
                                  p2sr_pkg::OP_SDIV_P2 : p2sr_pkg::OP_SMOD_P2;
          end
          res_next.shift_amount = pb.k;
          res_next.out_b_kind   = p2sr_pkg::KIND_NONE;
          res_next.out_b_imm    = 64'd0;
          res_next.out_b_reg    = 8'd0;
          res_next.was_changed  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // table update, after the rewrite
    wr_mark = 1'b0;
    wr_val  = a_val;
    if (res_next.new_opcode == p2sr_pkg::OP_MOVI) begin
      wr_mark = 1'b1;
      wr_val  = s1.a_imm;
    end else if (res_next.new_opcode == p2sr_pkg::OP_MOV) begin
      wr_mark = a_known;
    end
    wr_en = s1_go && s1.dst_valid && d_in && wr_mark;

    mark_next = mark;
    if (s1_go) begin
      if (s1.block_start) begin
        mark_next = '0;
      end
      if (s1.dst_valid && d_in) begin
        mark_next[wr_idx] = wr_mark;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark      <= '0;
      lw_en     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mark <= mark_next;
      if (wr_en) begin
        lw_en <= 1'b1;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
    if (wr_en) begin
      lw_addr <= wr_idx;
      lw_data <= wr_val;
    end
    if (s1_go) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, res.shift_amount, res.out_b_reg, res.out_b_imm,
                     res.out_a_reg, res.out_a_imm, res.new_opcode};
  assign m_tuser  = {res.was_changed, res.out_b_kind, res.out_a_kind};

`include "assert_macros.svh"

  `ASSERT_IMPL(a_shamt_div_only, clk, rst, out_valid && res.shift_amount != 6'd0, res.was_changed && (res.new_opcode == p2sr_pkg::OP_SDIV_P2 || res.new_opcode == p2sr_pkg::OP_UDIV_P2 || res.new_opcode == p2sr_pkg::OP_SMOD_P2 || res.new_opcode == p2sr_pkg::OP_UMOD_P2))
  `ASSERT_IMPL(a_shl_imm_count, clk, rst, out_valid && res.was_changed && res.new_opcode == p2sr_pkg::OP_SHL, res.out_b_kind == p2sr_pkg::KIND_IMM && res.out_b_imm < 64'd63 && res.out_b_reg == 8'd0)
  `ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !s1_go, s1_valid && $stable(s1))
  `ASSERT_IMPL(a_write_on_move, clk, rst, wr_en, s1_valid && (s1.opcode == p2sr_pkg::OP_MOVI || s1.opcode == p2sr_pkg::OP_MOV))

endmodule
